>>> rtl/mrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrs_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] FAULT_RAW  = 16'h7FFF;
    localparam logic [7:0]  EXC_FLAG   = 8'h80;
    localparam logic [7:0]  FN_READ    = 8'h03;
    localparam logic [7:0]  FN_WRITE   = 8'h06;
    localparam logic [15:0] LAST_REG   = 16'h0007;
    localparam logic [15:0] REG_COUNT  = 16'h0008;

    localparam logic [7:0]  EXC_NONE     = 8'h00;
    localparam logic [7:0]  EXC_FUNCTION = 8'h01;
    localparam logic [7:0]  EXC_ADDRESS  = 8'h02;
    localparam logic [7:0]  EXC_SENSOR   = 8'h04;
    localparam logic [7:0]  EXC_CRC      = 8'h08;

    localparam logic [7:0]  RESET_ADDR = 8'd26;
    localparam logic [2:0]  RESET_BAUD = 3'd7;

    localparam logic [1:0]  JOB_READ  = 2'd0;
    localparam logic [1:0]  JOB_WRITE = 2'd1;
    localparam logic [1:0]  JOB_EXC   = 2'd2;

    // Everything the response generator needs to build one reply frame.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  addr;
        logic [2:0]  baud;
        logic [7:0]  fn_byte;
        logic [7:0]  exc_code;
        logic [2:0]  start;
        logic [3:0]  qty;
        logic [31:0] echo;
        logic [15:0] temp;
        logic [7:0]  humi_lo;
        logic        crc_ok;
        logic        save;
    } job_t;

    // One byte of the reflected Modbus CRC-16.
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Holding register map.
    function automatic logic [15:0] hreg_value(
        input logic [2:0]  r,
        input logic [7:0]  addr,
        input logic [2:0]  baud,
        input logic [15:0] temp,
        input logic [7:0]  humi_lo
    );
        logic [15:0] v;
        case (r)
            3'd0:    v = {8'h00, addr};
            3'd1:    v = {13'h0000, baud};
            3'd2:    v = temp;
            3'd3:    v = 16'h0001;
            3'd4:    v = 16'h0002;
            3'd5:    v = {8'h00, humi_lo};
            3'd6:    v = 16'h0001;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mrs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mrs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_end,
    input  wire logic [15:0]   temperature,
    input  wire logic [15:0]   humidity,
    output logic               push,
    output mrs_pkg::job_t      job
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  hdr_reg [6];
    logic [7:0]  hdr_next [6];
    logic [15:0] tail_reg, tail_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  addr_reg, addr_next;
    logic [2:0]  baud_reg, baud_next;

    logic [15:0] rx_crc;
    logic        crc_ok;
    logic [7:0]  fn;
    logic [15:0] reg_num;
    logic [15:0] val;
    logic [7:0]  exc;
    logic        save;
    logic        addressed;

    always_comb
    begin
        for (int i = 0; i < 6; i++) begin
            hdr_next[i] = hdr_reg[i];
            if (count_reg == 8'(i))
            begin
                hdr_next[i] = rx_byte;
            end
        end
        crc_next   = (count_reg >= 8'd2) ? mrs_pkg::crc_add(crc_reg, tail_reg[15:8]) : crc_reg;
        tail_next  = {tail_reg[7:0], rx_byte};
        count_next = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;

        addressed = (hdr_next[0] == addr_reg);
        rx_crc    = {tail_next[7:0], tail_next[15:8]};
        crc_ok    = (rx_crc == crc_next);
        fn        = hdr_next[1];
        reg_num   = {hdr_next[2], hdr_next[3]};
        val       = {hdr_next[4], hdr_next[5]};

        addr_next = addr_reg;
        baud_next = baud_reg;
        exc       = mrs_pkg::EXC_NONE;
        save      = 1'b0;
        if (!crc_ok)
        begin
            exc = mrs_pkg::EXC_CRC;
        end
        else if (fn == mrs_pkg::FN_READ)
        begin
            if (temperature == mrs_pkg::FAULT_RAW || humidity == mrs_pkg::FAULT_RAW)
            begin
                exc = mrs_pkg::EXC_SENSOR;
            end
            else if (reg_num > mrs_pkg::LAST_REG || val < 16'd1
                     || val > (mrs_pkg::REG_COUNT - reg_num))
            begin
                exc = mrs_pkg::EXC_ADDRESS;
            end
        end
        else if (fn == mrs_pkg::FN_WRITE)
        begin
            if (reg_num == 16'd0 && val >= 16'd1 && val <= 16'd255)
            begin
                addr_next = val[7:0];
                save      = 1'b1;
            end
            else if (reg_num == 16'd1 && val <= 16'd7)
            begin
                baud_next = val[2:0];
                save      = 1'b1;
            end
            else
            begin
                exc = mrs_pkg::EXC_ADDRESS;
            end
        end
        else
        begin
            exc = mrs_pkg::EXC_FUNCTION;
        end

        job.addr     = addr_next;
        job.baud     = baud_next;
        job.crc_ok   = crc_ok;
        job.save     = save;
        job.exc_code = exc;
        job.start    = reg_num[2:0];
        job.qty      = val[3:0];
        job.echo     = {hdr_next[2], hdr_next[3], hdr_next[4], hdr_next[5]};
        job.temp     = temperature;
        job.humi_lo  = humidity[7:0];
        if (exc != mrs_pkg::EXC_NONE)
        begin
            job.kind    = mrs_pkg::JOB_EXC;
            job.fn_byte = fn + mrs_pkg::EXC_FLAG;
        end
        else if (fn == mrs_pkg::FN_READ)
        begin
            job.kind    = mrs_pkg::JOB_READ;
            job.fn_byte = fn;
        end
        else
        begin
            job.kind    = mrs_pkg::JOB_WRITE;
            job.fn_byte = fn;
        end

        push = accept && frame_end && addressed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= mrs_pkg::CRC_INIT;
            tail_reg  <= 16'h0000;
            count_reg <= 8'h00;
            addr_reg  <= mrs_pkg::RESET_ADDR;
            baud_reg  <= mrs_pkg::RESET_BAUD;
            for (int i = 0; i < 6; i++) begin
                hdr_reg[i] <= 8'h00;
            end
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                // Every frame end starts a fresh frame, answered or not.
                crc_reg   <= mrs_pkg::CRC_INIT;
                tail_reg  <= 16'h0000;
                count_reg <= 8'h00;
                for (int i = 0; i < 6; i++) begin
                    hdr_reg[i] <= 8'h00;
                end
                if (addressed)
                begin
                    addr_reg <= addr_next;
                    baud_reg <= baud_next;
                end
            end
            else
            begin
                crc_reg   <= crc_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                for (int i = 0; i < 6; i++) begin
                    hdr_reg[i] <= hdr_next[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mrs_queue #(
    parameter int DEPTH = mrs_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mrs_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output mrs_pkg::job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrs_pkg::job_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mrs_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire mrs_pkg::job_t job,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         tx_byte,
    output logic               tx_last,
    output logic               crc_ok,
    output logic               save_request,
    output logic [2:0]         baud_select,
    output logic [7:0]         own_address
);

    logic [4:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg, crc_ok_reg, save_reg;
    logic [2:0]  baud_reg;
    logic [7:0]  addr_reg;

    logic        advance;
    logic [4:0]  body_len;
    logic [4:0]  k;
    logic [2:0]  r;
    logic [15:0] hv;
    logic [7:0]  body_byte;
    logic [7:0]  cur_byte;
    logic        in_body;
    logic        is_last;

    always_comb
    begin
        advance = job_valid && (!valid_reg || !out_stall);

        case (job.kind)
            mrs_pkg::JOB_READ:  body_len = 5'd3 + {job.qty, 1'b0};
            mrs_pkg::JOB_WRITE: body_len = 5'd6;
            default:            body_len = 5'd3;
        endcase

        k  = idx_reg - 5'd3;
        r  = job.start + k[3:1];
        hv = mrs_pkg::hreg_value(r, job.addr, job.baud, job.temp, job.humi_lo);

        body_byte = 8'h00;
        case (idx_reg)
            5'd0:    body_byte = job.addr;
            5'd1:    body_byte = job.fn_byte;
            5'd2:
            begin
                case (job.kind)
                    mrs_pkg::JOB_READ:  body_byte = {3'b000, job.qty, 1'b0};
                    mrs_pkg::JOB_WRITE: body_byte = job.echo[31:24];
                    default:            body_byte = job.exc_code;
                endcase
            end
            default:
            begin
                if (job.kind == mrs_pkg::JOB_WRITE)
                begin
                    case (idx_reg)
                        5'd3:    body_byte = job.echo[23:16];
                        5'd4:    body_byte = job.echo[15:8];
                        default: body_byte = job.echo[7:0];
                    endcase
                end
                else
                begin
                    body_byte = k[0] ? hv[7:0] : hv[15:8];
                end
            end
        endcase

        in_body = (idx_reg < body_len);
        is_last = (idx_reg == body_len + 5'd1);
        if (in_body)
        begin
            cur_byte = body_byte;
        end
        else if (idx_reg == body_len)
        begin
            cur_byte = crc_reg[7:0];
        end
        else
        begin
            cur_byte = crc_reg[15:8];
        end

        pop = advance && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 5'd0;
            crc_reg   <= mrs_pkg::CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= 1'b1;
                if (is_last)
                begin
                    idx_reg <= 5'd0;
                    crc_reg <= mrs_pkg::CRC_INIT;
                end
                else
                begin
                    idx_reg <= idx_reg + 5'd1;
                    if (in_body)
                    begin
                        crc_reg <= mrs_pkg::crc_add(crc_reg, body_byte);
                    end
                end
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg   <= cur_byte;
            last_reg   <= is_last;
            crc_ok_reg <= job.crc_ok;
            save_reg   <= job.save;
            baud_reg   <= job.baud;
            addr_reg   <= job.addr;
        end
    end

    assign out_valid    = valid_reg;
    assign tx_byte      = byte_reg;
    assign tx_last      = last_reg;
    assign crc_ok       = crc_ok_reg;
    assign save_request = save_reg;
    assign baud_select  = baud_reg;
    assign own_address  = addr_reg;

endmodule

`default_nettype wire

>>> rtl/modbus_rtu_sensor_slave.sv
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU slave for a temperature and humidity sensor with eight holding
// registers. Request bytes enter one per transfer on the input channel, with
// frame_end set on the last byte of a frame (the gap timer lives outside this
// block). The front end takes one byte every clock cycle while the job queue is
// not full: it runs the CRC-16 over everything but the two trailing CRC bytes,
// keeps the first six bytes as the header, and at frame end decides the reply
// and applies any address or baud index write. A frame whose first byte is not
// this slave's address is dropped without a reply. Each reply is described by
// one entry in a short job queue (QUEUE_DEPTH entries), and the back end plays
// it out as one response byte per transfer, one byte per cycle unless stalled,
// computing the reply CRC as it goes and appending it low byte first; tx_last marks the
// final byte. A reply is 5 to 21 bytes long. The input channel stalls only
// while the job queue is full, which happens once QUEUE_DEPTH replies are
// pending at the same time, the one being played out included. After reset
// the slave answers at address 26 with baud index 7; crc_ok, save_request,
// baud_select and own_address travel with every response byte and reflect the
// state after that request.
module modbus_rtu_sensor_slave #(
    parameter int QUEUE_DEPTH = mrs_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_end,
    input  wire logic signed [15:0] temperature,
    input  wire logic signed [15:0] humidity,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       tx_byte,
    output logic             tx_last,
    output logic             crc_ok,
    output logic             save_request,
    output logic [2:0]       baud_select,
    output logic [7:0]       own_address
);

    logic          accept;
    logic          push;
    mrs_pkg::job_t push_job;
    logic          q_full;
    logic          q_not_empty;
    mrs_pkg::job_t head_job;
    logic          pop;

    // The input stalls only on a full queue, so a byte is never half taken.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    mrs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .frame_end   (frame_end),
        .temperature (temperature),
        .humidity    (humidity),
        .push        (push),
        .job         (push_job)
    );

    mrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    mrs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_not_empty),
        .job          (head_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_byte      (tx_byte),
        .tx_last      (tx_last),
        .crc_ok       (crc_ok),
        .save_request (save_request),
        .baud_select  (baud_select),
        .own_address  (own_address)
    );

endmodule

`default_nettype wire
